### sv/rv32dec_pkg.sv
// Shared types and encodings for the RV32 subset instruction decoder.
`default_nettype none
package rv32dec_pkg;

	localparam int unsigned WordWidth = 32;

	typedef logic [WordWidth-1:0] word_t;
	typedef logic [2:0]           op_class_t;
	typedef logic [3:0]           operation_t;
	typedef logic [4:0]           reg_idx_t;
	typedef logic [6:0]           opcode_t;
	typedef logic [2:0]           funct3_t;
	typedef logic [6:0]           funct7_t;

	// major opcodes
	localparam opcode_t OPC_R      = 7'b0110011;
	localparam opcode_t OPC_I      = 7'b0010011;
	localparam opcode_t OPC_JALR   = 7'b1100111;
	localparam opcode_t OPC_BRANCH = 7'b1100011;
	localparam opcode_t OPC_LOAD   = 7'b0000011;
	localparam opcode_t OPC_STORE  = 7'b0100011;

	// instruction classes
	localparam op_class_t CLS_R      = 3'd0;
	localparam op_class_t CLS_I      = 3'd1;
	localparam op_class_t CLS_JALR   = 3'd2;
	localparam op_class_t CLS_BRANCH = 3'd3;
	localparam op_class_t CLS_LOAD   = 3'd4;
	localparam op_class_t CLS_STORE  = 3'd5;
	localparam op_class_t CLS_NONE   = 3'd6;

	// operations
	localparam operation_t OP_ADD  = 4'd0;
	localparam operation_t OP_SUB  = 4'd1;
	localparam operation_t OP_XOR  = 4'd2;
	localparam operation_t OP_SRA  = 4'd3;
	localparam operation_t OP_ADDI = 4'd4;
	localparam operation_t OP_ANDI = 4'd5;
	localparam operation_t OP_BLT  = 4'd6;
	localparam operation_t OP_JALR = 4'd7;
	localparam operation_t OP_LW   = 4'd8;
	localparam operation_t OP_SW   = 4'd9;
	localparam operation_t OP_UNK  = 4'd10;

	// funct codes
	localparam funct3_t F3_ADD  = 3'd0;
	localparam funct3_t F3_XOR  = 3'd4;
	localparam funct3_t F3_SRA  = 3'd5;
	localparam funct3_t F3_ANDI = 3'd7;
	localparam funct3_t F3_BLT  = 3'd4;
	localparam funct3_t F3_WORD = 3'd2;
	localparam funct7_t F7_BASE = 7'h00;
	localparam funct7_t F7_ALT  = 7'h20;

	typedef struct packed {
		op_class_t         op_class;
		operation_t        operation;
		reg_idx_t          dest_reg;
		reg_idx_t          src_reg_one;
		reg_idx_t          src_reg_two;
		logic signed [WordWidth-1:0] immediate;
	} decode_t;

endpackage
`default_nettype wire

### sv/rv32dec_decode.sv
// Combinational field split, class and operation naming, immediate build.
`default_nettype none
module rv32dec_decode
	import rv32dec_pkg::*;
(
	input  word_t   word,
	output decode_t result
);

	opcode_t    opcode;
	funct3_t    f3;
	funct7_t    f7;
	op_class_t  cls;
	operation_t op;
	logic signed [WordWidth-1:0] imm;

	assign opcode = word[6:0];
	assign f3     = word[14:12];
	assign f7     = word[31:25];

	always_comb begin
		unique case (opcode)
			OPC_R:      cls = CLS_R;
			OPC_I:      cls = CLS_I;
			OPC_JALR:   cls = CLS_JALR;
			OPC_BRANCH: cls = CLS_BRANCH;
			OPC_LOAD:   cls = CLS_LOAD;
			OPC_STORE:  cls = CLS_STORE;
			default:    cls = CLS_NONE;
		endcase
	end

	// unmatched funct codes stay within their class and name nothing
	always_comb begin
		op = OP_UNK;
		unique case (cls)
			CLS_R: begin
				priority if (f3 == F3_ADD && f7 == F7_BASE) op = OP_ADD;
				else if (f3 == F3_ADD && f7 == F7_ALT)      op = OP_SUB;
				else if (f3 == F3_XOR && f7 == F7_BASE)     op = OP_XOR;
				else if (f3 == F3_SRA && f7 == F7_ALT)      op = OP_SRA;
				else                                        op = OP_UNK;
			end
			CLS_I: begin
				priority if (f3 == F3_ADD) op = OP_ADDI;
				else if (f3 == F3_ANDI)    op = OP_ANDI;
				else                       op = OP_UNK;
			end
			CLS_BRANCH: op = (f3 == F3_BLT) ? OP_BLT : OP_UNK;
			CLS_JALR:   op = OP_JALR;
			CLS_LOAD:   op = (f3 == F3_WORD) ? OP_LW : OP_UNK;
			CLS_STORE:  op = (f3 == F3_WORD) ? OP_SW : OP_UNK;
			default:    op = OP_UNK;
		endcase
	end

	always_comb begin
		unique case (cls)
			CLS_I, CLS_JALR, CLS_LOAD:
				imm = {{20{word[31]}}, word[31:20]};
			CLS_STORE:
				imm = {{20{word[31]}}, word[31:25], word[11:7]};
			CLS_BRANCH:
				imm = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
			default:
				imm = '0;
		endcase
	end

	assign result.op_class    = cls;
	assign result.operation   = op;
	assign result.dest_reg    = word[11:7];
	assign result.src_reg_one = word[19:15];
	assign result.src_reg_two = word[24:20];
	assign result.immediate   = imm;

endmodule
`default_nettype wire

### sv/rv32_subset_instruction_decoder_core.sv
// RV32 subset instruction decoder: input register, decode logic, result register.
// Takes one instruction word per cycle while the output is not stalled and returns
// one decoded result per word. A word enters the input register when accepted,
// is decoded, and lands in the result register when that register advances; its
// result is then offered there until taken. Each register loads whenever it is
// empty or its contents are being drained, so in_ready follows out_ready
// combinationally and the block sustains one request per cycle under continuous
// downstream ready. Results come out in request order; nothing is dropped or
// repeated under stalls on either side.
`default_nettype none
module rv32_subset_instruction_decoder_core
	import rv32dec_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] instruction_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       op_class,
	output logic [3:0]       operation,
	output logic [4:0]       dest_reg,
	output logic [4:0]       src_reg_one,
	output logic [4:0]       src_reg_two,
	output logic signed [31:0] immediate
);

	logic    valid_s1;
	word_t   word_s1;
	logic    valid_s2;
	decode_t result_s2;
	decode_t decoded;
	logic    adv_s2;
	logic    adv_s1;

	// a stage may load when it is empty or its contents leave this cycle
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	rv32dec_decode u_decode (
		.word   (word_s1),
		.result (decoded)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) word_s1 <= instruction_word;
		if (adv_s2 && valid_s1) result_s2 <= decoded;
	end

	assign out_valid   = valid_s2;
	assign op_class    = result_s2.op_class;
	assign operation   = result_s2.operation;
	assign dest_reg    = result_s2.dest_reg;
	assign src_reg_one = result_s2.src_reg_one;
	assign src_reg_two = result_s2.src_reg_two;
	assign immediate   = result_s2.immediate;

endmodule
`default_nettype wire

### tb/tb_rv32_subset_instruction_decoder_core.sv
// Testbench for the RV32 subset instruction decoder core with a decode predictor.
module tb_rv32_subset_instruction_decoder_core;
	import rv32dec_pkg::*;

	localparam int unsigned QuietLimit   = 2000;
	localparam int unsigned HoldOffLen   = 300;
	localparam int unsigned MaxReports   = 10;

	// encodings outside the decoded subset, plus funct7 values for immediate extremes
	localparam opcode_t OPC_LUI  = 7'b0110111;
	localparam funct3_t F3_SLL   = 3'd1;
	localparam funct3_t F3_SLTU  = 3'd3;
	localparam funct3_t F3_AND   = 3'd7;
	localparam funct7_t F7_ODD   = 7'h01;
	localparam funct7_t F7_ONES  = 7'h7f;
	localparam funct7_t F7_IMAX  = 7'h3f;
	localparam funct7_t F7_IMIN  = 7'h40;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [31:0]      instruction_word;
	logic             out_valid;
	logic             out_ready;
	logic [2:0]       op_class;
	logic [3:0]       operation;
	logic [4:0]       dest_reg;
	logic [4:0]       src_reg_one;
	logic [4:0]       src_reg_two;
	logic signed [31:0] immediate;

	decode_t     pending_decodes[$];
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned send_gap_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_off_len;

	rv32_subset_instruction_decoder_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.instruction_word (instruction_word),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.op_class         (op_class),
		.operation        (operation),
		.dest_reg         (dest_reg),
		.src_reg_one      (src_reg_one),
		.src_reg_two      (src_reg_two),
		.immediate        (immediate)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic decode_t decode_word(input word_t w);
		decode_t d;
		opcode_t opc;
		funct3_t f3;
		funct7_t f7;
		word_t   imm_i;
		opc = w[6:0];
		f3  = w[14:12];
		f7  = w[31:25];
		imm_i = {{20{w[31]}}, w[31:20]};
		d.dest_reg    = w[11:7];
		d.src_reg_one = w[19:15];
		d.src_reg_two = w[24:20];
		d.operation   = OP_UNK;
		d.immediate   = '0;
		case (opc)
		OPC_R: begin
			d.op_class = CLS_R;
			if (f3 == F3_ADD && f7 == F7_BASE)
				d.operation = OP_ADD;
			else if (f3 == F3_ADD && f7 == F7_ALT)
				d.operation = OP_SUB;
			else if (f3 == F3_XOR && f7 == F7_BASE)
				d.operation = OP_XOR;
			else if (f3 == F3_SRA && f7 == F7_ALT)
				d.operation = OP_SRA;
		end
		OPC_I: begin
			d.op_class  = CLS_I;
			d.immediate = imm_i;
			if (f3 == F3_ADD)
				d.operation = OP_ADDI;
			else if (f3 == F3_ANDI)
				d.operation = OP_ANDI;
		end
		OPC_JALR: begin
			d.op_class  = CLS_JALR;
			d.operation = OP_JALR;
			d.immediate = imm_i;
		end
		OPC_BRANCH: begin
			d.op_class  = CLS_BRANCH;
			d.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
			if (f3 == F3_BLT)
				d.operation = OP_BLT;
		end
		OPC_LOAD: begin
			d.op_class  = CLS_LOAD;
			d.immediate = imm_i;
			if (f3 == F3_WORD)
				d.operation = OP_LW;
		end
		OPC_STORE: begin
			d.op_class  = CLS_STORE;
			d.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
			if (f3 == F3_WORD)
				d.operation = OP_SW;
		end
		default: begin
			d.op_class = CLS_NONE;
		end
		endcase
		return d;
	endfunction

	function automatic word_t encode(input opcode_t opc, input funct3_t f3, input funct7_t f7,
			input reg_idx_t rd, input reg_idx_t rs1, input reg_idx_t rs2);
		return {f7, rs2, rs1, f3, rd, opc};
	endfunction

	// mostly well-formed subset encodings with random fields, some raw noise
	function automatic word_t random_word();
		word_t       w;
		opcode_t     opc;
		bit          legal;
		w = $urandom();
		if ($urandom_range(99) < 12)
			return w;
		legal = ($urandom_range(3) != 0);
		case ($urandom_range(5))
		0: opc = OPC_R;
		1: opc = OPC_I;
		2: opc = OPC_JALR;
		3: opc = OPC_BRANCH;
		4: opc = OPC_LOAD;
		default: opc = OPC_STORE;
		endcase
		w[6:0] = opc;
		if (legal) begin
			case (opc)
			OPC_R: begin
				case ($urandom_range(3))
				0: begin w[14:12] = F3_ADD; w[31:25] = F7_BASE; end
				1: begin w[14:12] = F3_ADD; w[31:25] = F7_ALT;  end
				2: begin w[14:12] = F3_XOR; w[31:25] = F7_BASE; end
				default: begin w[14:12] = F3_SRA; w[31:25] = F7_ALT; end
				endcase
			end
			OPC_I:      w[14:12] = $urandom_range(1) ? F3_ADD : F3_ANDI;
			OPC_BRANCH: w[14:12] = F3_BLT;
			OPC_LOAD,
			OPC_STORE:  w[14:12] = F3_WORD;
			default: ;
			endcase
		end
		return w;
	endfunction

	task automatic send_word(input word_t w);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid         <= 1'b1;
		instruction_word <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// drop valid and hold it low until every result is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_decodes.size() != 0);
	endtask

	task automatic run_random(input int unsigned count, input int unsigned gap_pct,
			input int unsigned stall_pct);
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			send_word(random_word());
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= MaxReports)
				$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// track accepted words and compare each result with the oldest prediction
	always @(posedge clk) begin
		decode_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				pending_decodes.push_back(decode_word(instruction_word));
			if (out_valid && out_ready) begin
				if (pending_decodes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MaxReports)
						$display("%0t: result with nothing expected: class %0d op %0d",
							$time, op_class, operation);
				end else begin
					want = pending_decodes.pop_front();
					check_field("op_class",    32'(want.op_class),    32'(op_class));
					check_field("operation",   32'(want.operation),   32'(operation));
					check_field("dest_reg",    32'(want.dest_reg),    32'(dest_reg));
					check_field("src_reg_one", 32'(want.src_reg_one), 32'(src_reg_one));
					check_field("src_reg_two", 32'(want.src_reg_two), 32'(src_reg_two));
					check_field("immediate",   want.immediate,        immediate);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles + 1 >= QuietLimit) begin
			$display("tb_rv32_subset_instruction_decoder_core: FAIL");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// receiver: random stalls, plus a long hold-off on demand
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_len != 0) begin
				out_ready <= 1'b0;
				repeat (hold_off_len)
					@(negedge clk);
				hold_off_len = 0;
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic test_directed();
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		send_word(32'h0000_0000);
		send_word(32'hffff_ffff);
		send_word(encode(OPC_R, F3_ADD, F7_BASE, 5'd31, 5'd0, 5'd31));
		send_word(encode(OPC_R, F3_ADD, F7_ALT, 5'd1, 5'd2, 5'd3));
		send_word(encode(OPC_R, F3_XOR, F7_BASE, 5'd0, 5'd31, 5'd0));
		send_word(encode(OPC_R, F3_SRA, F7_ALT, 5'd17, 5'd10, 5'd21));
		send_word(encode(OPC_R, F3_ADD, F7_ODD, 5'd4, 5'd5, 5'd6));
		send_word(encode(OPC_R, F3_XOR, F7_ALT, 5'd7, 5'd8, 5'd9));
		send_word(encode(OPC_R, F3_AND, F7_ONES, 5'd31, 5'd31, 5'd31));
		send_word(encode(OPC_I, F3_ADD, F7_IMAX, 5'd5, 5'd6, 5'd31));
		send_word(encode(OPC_I, F3_ADD, F7_IMIN, 5'd5, 5'd6, 5'd0));
		send_word(encode(OPC_I, F3_ANDI, F7_ONES, 5'd12, 5'd13, 5'd31));
		send_word(encode(OPC_I, F3_SLL, F7_BASE, 5'd2, 5'd3, 5'd4));
		send_word(encode(OPC_JALR, F3_ADD, F7_IMAX, 5'd1, 5'd1, 5'd30));
		send_word(encode(OPC_JALR, F3_AND, F7_IMIN, 5'd0, 5'd9, 5'd1));
		send_word(encode(OPC_JALR, F3_AND, F7_ONES, 5'd31, 5'd31, 5'd31));
		send_word(encode(OPC_BRANCH, F3_BLT, F7_IMAX, 5'd31, 5'd14, 5'd15));
		send_word(encode(OPC_BRANCH, F3_BLT, F7_IMIN, 5'd0, 5'd16, 5'd17));
		send_word(encode(OPC_BRANCH, F3_ADD, F7_ONES, 5'd30, 5'd18, 5'd19));
		send_word(encode(OPC_LOAD, F3_WORD, F7_IMIN, 5'd10, 5'd2, 5'd8));
		send_word(encode(OPC_LOAD, F3_ADD, F7_IMAX, 5'd11, 5'd2, 5'd31));
		send_word(encode(OPC_STORE, F3_WORD, F7_IMAX, 5'd31, 5'd2, 5'd20));
		send_word(encode(OPC_STORE, F3_WORD, F7_IMIN, 5'd0, 5'd2, 5'd21));
		send_word(encode(OPC_STORE, F3_SLTU, F7_ONES, 5'd15, 5'd3, 5'd22));
		send_word(encode(OPC_LUI, F3_ADD, F7_ONES, 5'd25, 5'd26, 5'd27));
	endtask

	task automatic test_streaming();
		run_random(450, 0, 0);
	endtask

	task automatic test_sender_gaps();
		run_random(350, 45, 0);
	endtask

	task automatic test_receiver_stalls();
		run_random(350, 0, 45);
	endtask

	task automatic test_both_idle();
		run_random(350, 24, 24);
	endtask

	task automatic test_backpressure();
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		hold_off_len = HoldOffLen;
		@(negedge clk);
		// keep offering words while the output is held off
		run_random(120, 0, 0);
		wait_drained();
		run_random(130, 0, 0);
	endtask

	initial begin
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		instruction_word = '0;
		send_gap_pct     = 0;
		recv_stall_pct   = 0;
		hold_off_len     = 0;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_streaming();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		test_backpressure();

		wait_drained();
		repeat (8)
			@(negedge clk);
		if (mismatch_count == 0)
			$display("tb_rv32_subset_instruction_decoder_core: PASS");
		else
			$display("tb_rv32_subset_instruction_decoder_core: FAIL");
		$finish;
	end

endmodule
